@@ rtl/core/dssm_pkg.sv @@
// ============================================================================
// dssm_pkg
// Shared types and codes for the dual stack in one shared memory.
// ============================================================================
package dssm_pkg;

    // Field widths fixed by the stream payload
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    // Operation codes; the unused code behaves as a peek
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2
    } t_cmd;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_DONE  = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } t_status;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the input item and start the top-of-stack read
        logic exec;   // update the stack, write memory, load the result register
    } t_ctrl_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;   // result register is empty or drains this cycle
    } t_dp_stat;

endpackage

@@ rtl/core/dssm_ram.sv @@
// ============================================================================
// dssm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module dssm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/dssm_ctrl.sv @@
// ============================================================================
// dssm_ctrl
// Two-state sequencer: accept an item, then execute it in the next cycle.
// ============================================================================
module dssm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dssm_pkg::t_dp_stat  i_stat,
    output dssm_pkg::t_ctrl_cmd o_cmd
);

    import dssm_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                // Take an item only when the result register will be free
                o_in_ready = i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/dssm_dp.sv @@
// ============================================================================
// dssm_dp
// Datapath: fill counters, shared word store, top selection, result register.
// ============================================================================
module dssm_dp #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dssm_pkg::t_ctrl_cmd               i_cmd,
    output dssm_pkg::t_dp_stat                o_stat,
    input  logic [dssm_pkg::CMD_W-1:0]        i_op,
    input  logic                              i_sel,
    input  logic [dssm_pkg::WORD_W-1:0]       i_word,
    input  logic                              i_m_ready,
    output logic                              o_m_valid,
    output logic [dssm_pkg::STATUS_W-1:0]     o_status,
    output logic [dssm_pkg::WORD_W-1:0]       o_top,
    output logic [dssm_pkg::COUNT_W-1:0]      o_count_a,
    output logic [dssm_pkg::COUNT_W-1:0]      o_count_b
);

    import dssm_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW:0] DEPTH_S = (CW + 1)'(DEPTH);
    localparam logic [CW:0] DEPTH_M1 = (CW + 1)'(DEPTH - 1);

    // Captured item
    logic [CMD_W-1:0]  r_op;
    logic              r_sel;
    logic [WORD_W-1:0] r_word;

    // Stack occupancy
    logic [CW-1:0] r_fill_a;
    logic [CW-1:0] n_fill_a;
    logic [CW-1:0] r_fill_b;
    logic [CW-1:0] n_fill_b;

    // Result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [WORD_W-1:0]   r_out_top;
    logic [CW-1:0]       r_out_fill_a;
    logic [CW-1:0]       r_out_fill_b;

    // Memory ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic              is_pop_in;
    logic [CW:0]       raddr_a;
    logic [CW:0]       raddr_b;
    logic [CW:0]       waddr_b;
    logic [CW:0]       fill_sum;
    logic [CW-1:0]     fill_sel;
    t_status           exec_status;
    logic [WORD_W-1:0] exec_top;

    // Read address of the top after the operation: a pop reads one deeper
    assign is_pop_in = (i_op == CMD_POP);
    assign raddr_a   = {1'b0, r_fill_a} - (CW + 1)'(1) - (CW + 1)'(is_pop_in);
    assign raddr_b   = DEPTH_S - {1'b0, r_fill_b} + (CW + 1)'(is_pop_in);
    assign ram_raddr = i_sel ? raddr_b[AW-1:0] : raddr_a[AW-1:0];

    // Write address of a push
    assign waddr_b   = DEPTH_M1 - {1'b0, r_fill_b};
    assign ram_waddr = r_sel ? waddr_b[AW-1:0] : r_fill_a[AW-1:0];

    assign fill_sum = {1'b0, r_fill_a} + {1'b0, r_fill_b};
    assign fill_sel = r_sel ? r_fill_b : r_fill_a;

    // Execute the captured operation
    always_comb begin
        n_fill_a    = r_fill_a;
        n_fill_b    = r_fill_b;
        ram_we      = 1'b0;
        exec_status = STS_DONE;
        exec_top    = ram_rdata;
        case (r_op)
            CMD_PUSH: begin
                if (fill_sum >= DEPTH_S) begin
                    exec_status = STS_FULL;
                    if (fill_sel == '0) begin
                        exec_top = '1;
                    end
                end else begin
                    ram_we   = i_cmd.exec;
                    exec_top = r_word;
                    if (r_sel) begin
                        n_fill_b = r_fill_b + CW'(1);
                    end else begin
                        n_fill_a = r_fill_a + CW'(1);
                    end
                end
            end
            CMD_POP: begin
                if (fill_sel == '0) begin
                    exec_status = STS_EMPTY;
                    exec_top    = '1;
                end else begin
                    if (fill_sel == CW'(1)) begin
                        exec_top = '1;
                    end
                    if (r_sel) begin
                        n_fill_b = r_fill_b - CW'(1);
                    end else begin
                        n_fill_a = r_fill_a - CW'(1);
                    end
                end
            end
            default: begin
                // Peek, and the unused code
                if (fill_sel == '0) begin
                    exec_status = STS_EMPTY;
                    exec_top    = '1;
                end
            end
        endcase
    end

    dssm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_word),
        .i_re    (i_cmd.load),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_sel  <= i_sel;
            r_word <= i_word;
        end
    end

    // Advance the fill counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_a <= '0;
            r_fill_b <= '0;
        end else if (i_cmd.exec) begin
            r_fill_a <= n_fill_a;
            r_fill_b <= n_fill_b;
        end
    end

    // Result valid: set on execute, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_status <= exec_status;
            r_out_top    <= exec_top;
            r_out_fill_a <= n_fill_a;
            r_out_fill_b <= n_fill_b;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_m_ready;
    assign o_m_valid       = r_out_valid;
    assign o_status        = r_out_status;
    assign o_top           = r_out_top;
    assign o_count_a       = COUNT_W'(r_out_fill_a);
    assign o_count_b       = COUNT_W'(r_out_fill_b);

endmodule

@@ rtl/core/dual_stack_shared_memory.sv @@
// ============================================================================
// dual_stack_shared_memory
// Two LIFO stacks sharing one word store; stack A grows up, stack B down.
// ============================================================================
// Usage:
//   Input stream s_axis: tdata carries the word to push, tuser carries the
//   operation (push, pop, peek) and the stack select. Output stream m_axis:
//   tuser carries the status (done, full, empty), tdata the new top of the
//   addressed stack (all ones when empty) and both occupancy counts.
//   Each item gives exactly one result.
//   The top-of-stack read is launched in the accept cycle from the
//   current fill counts and the registered RAM read returns in the
//   execute cycle, where the counts update and the result register loads.
//   A new item is taken only after the previous one has executed, while
//   the receiver keeps up.
//   Stall: the result register holds until taken; s_axis_tready stays low
//   while a result waits and is not being taken in that cycle.
//   Reset (i_rst_n low, synchronous): both stacks empty, no result pending.
//   The word store itself is not cleared; only written entries reach the output.
// ============================================================================
module dual_stack_shared_memory #(
    parameter int unsigned DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [2:0]  s_axis_tuser,   // [1:0] cmd, [2] which_stack
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] top_value, [36:32] count_a,
                                        // [41:37] count_b, [47:42] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    import dssm_pkg::*;

    t_ctrl_cmd         ctrl_cmd;
    t_dp_stat          dp_stat;
    logic [WORD_W-1:0] out_top;
    logic [COUNT_W-1:0] out_count_a;
    logic [COUNT_W-1:0] out_count_b;

    dssm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (ctrl_cmd)
    );

    dssm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (ctrl_cmd),
        .o_stat    (dp_stat),
        .i_op      (s_axis_tuser[1:0]),
        .i_sel     (s_axis_tuser[2]),
        .i_word    (s_axis_tdata),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_status  (m_axis_tuser),
        .o_top     (out_top),
        .o_count_a (out_count_a),
        .o_count_b (out_count_b)
    );

    // Pack the result payload
    assign m_axis_tdata = {6'd0, out_count_b, out_count_a, out_top};

endmodule
